>>> rtl/core/pwp_pkg.sv
// shared types and constants for the protobuf wire parser
`default_nettype none
package pwp_pkg;

	localparam int MAX_VARINT_BYTES = 10;

	// wire types taken from the low three tag bits
	localparam logic [2:0] WT_VINT    = 3'd0;
	localparam logic [2:0] WT_FIX64   = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_VARINT,
		PH_LEN,
		PH_PAYLOAD,
		PH_FIX32,
		PH_FIX64,
		PH_DRAIN
	} phase_t;

	typedef enum logic [2:0] {
		K_VARINT  = 3'd0,
		K_FIXED32 = 3'd1,
		K_LEN_HDR = 3'd2,
		K_PAYLOAD = 3'd3,
		K_MSG_OK  = 3'd4,
		K_MSG_ERR = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE      = 2'd0,
		E_TOO_LONG  = 2'd1,
		E_TRUNCATED = 2'd2,
		E_BAD_WIRE  = 2'd3
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] field_number;
		logic [63:0] value;
		logic        final_payload_byte;
		err_t        error_code;
		logic        last_result;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/pwp_decode.sv
// parse state and per-byte decode logic
`default_nettype none
module pwp_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic [7:0]      byte_in,
	input  wire logic            end_of_message,
	output pwp_pkg::result_t     res0,
	output pwp_pkg::result_t     res1,
	output logic [1:0]           push_cnt
);
	import pwp_pkg::*;

	// number of 7-bit groups that still land inside 64 bits
	localparam int VARINT_SLOTS = (64 + 6) / 7;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [63:0] acc_q, acc_d;
	logic [31:0] field_q, field_d;
	logic [63:0] remain_q, remain_d;

	logic [3:0]  cnt_inc;
	logic [6:0]  vshift;
	logic [63:0] vpart;
	logic [63:0] acc_var;
	logic [63:0] acc_fix;
	logic [63:0] rem_dec;

	result_t     r;
	result_t     e;
	logic        r_v;
	logic        e_v;

	assign cnt_inc = cnt_q + 4'd1;
	assign vshift  = 7'(cnt_q) * 7'd7;
	assign vpart   = (cnt_q < 4'(VARINT_SLOTS)) ? ({57'd0, byte_in[6:0]} << vshift) : '0;
	assign acc_var = acc_q | vpart;
	assign acc_fix = acc_q | ({56'd0, byte_in} << {cnt_q[1:0], 3'b000});
	assign rem_dec = remain_q - 64'd1;

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		acc_d    = acc_q;
		field_d  = field_q;
		remain_d = remain_q;
		r_v      = 1'b0;
		r        = '0;
		case (phase_q)
			PH_TAG, PH_VARINT, PH_LEN: begin
				acc_d = acc_var;
				cnt_d = cnt_inc;
				if (!byte_in[7]) begin
					acc_d = '0;
					cnt_d = '0;
					case (phase_q)
						PH_TAG: begin
							field_d = acc_var[34:3];
							case (acc_var[2:0])
								WT_VINT:    phase_d = PH_VARINT;
								WT_LEN:     phase_d = PH_LEN;
								WT_FIXED32: phase_d = PH_FIX32;
								WT_FIX64:   phase_d = PH_FIX64;
								default: begin
									r_v          = 1'b1;
									r.kind       = K_MSG_ERR;
									r.error_code = E_BAD_WIRE;
									phase_d      = PH_DRAIN;
								end
							endcase
						end
						PH_VARINT: begin
							r_v            = 1'b1;
							r.kind         = K_VARINT;
							r.field_number = field_q;
							r.value        = acc_var;
							phase_d        = PH_TAG;
						end
						default: begin
							r_v            = 1'b1;
							r.kind         = K_LEN_HDR;
							r.field_number = field_q;
							r.value        = acc_var;
							remain_d       = acc_var;
							phase_d        = (acc_var == 64'd0) ? PH_TAG : PH_PAYLOAD;
						end
					endcase
				end else if (cnt_inc >= 4'(MAX_VARINT_BYTES)) begin
					r_v          = 1'b1;
					r.kind       = K_MSG_ERR;
					r.error_code = E_TOO_LONG;
					phase_d      = PH_DRAIN;
				end
			end
			PH_PAYLOAD: begin
				remain_d             = rem_dec;
				r_v                  = 1'b1;
				r.kind               = K_PAYLOAD;
				r.field_number       = field_q;
				r.value              = {56'd0, byte_in};
				r.final_payload_byte = (rem_dec == 64'd0);
				if (rem_dec == 64'd0) begin
					phase_d = PH_TAG;
				end
			end
			PH_FIX32: begin
				acc_d = acc_fix;
				cnt_d = cnt_inc;
				if (cnt_inc >= 4'd4) begin
					r_v            = 1'b1;
					r.kind         = K_FIXED32;
					r.field_number = field_q;
					r.value        = {32'd0, acc_fix[31:0]};
					acc_d          = '0;
					cnt_d          = '0;
					phase_d        = PH_TAG;
				end
			end
			PH_FIX64: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= 4'd8) begin
					acc_d   = '0;
					cnt_d   = '0;
					phase_d = PH_TAG;
				end
			end
			default: ;
		endcase

		// message close: ok, or truncated unless already in error
		e_v = 1'b0;
		e   = '0;
		if (end_of_message) begin
			if (phase_d == PH_TAG) begin
				e_v    = 1'b1;
				e.kind = K_MSG_OK;
			end else if (phase_d != PH_DRAIN) begin
				e_v          = 1'b1;
				e.kind       = K_MSG_ERR;
				e.error_code = E_TRUNCATED;
			end
			phase_d  = PH_TAG;
			cnt_d    = '0;
			acc_d    = '0;
			field_d  = '0;
			remain_d = '0;
		end
	end

	always_comb begin
		if (r_v) begin
			res0 = r;
		end else begin
			res0 = e;
		end
		res0.last_result = !(r_v && e_v);
		res1             = e;
		res1.last_result = 1'b1;
		push_cnt         = 2'(r_v) + 2'(e_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			cnt_q    <= '0;
			acc_q    <= '0;
			field_q  <= '0;
			remain_q <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			acc_q    <= acc_d;
			field_q  <= field_d;
			remain_q <= remain_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/pwp_out_fifo.sv
// four-entry result queue, takes up to two results per cycle
`default_nettype none
module pwp_out_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_cnt,
	input  wire pwp_pkg::result_t  res0,
	input  wire pwp_pkg::result_t  res1,
	input  wire logic              out_ready,
	output pwp_pkg::result_t       out_res,
	output logic                   out_valid,
	output logic                   room
);
	import pwp_pkg::*;

	result_t    slot_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 3'd0);
	assign out_res   = slot_q[rd_q];
	assign pop       = out_valid && out_ready;
	// room for a worst-case two-result word
	assign room      = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			slot_q[wr_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			slot_q[wr_q + 2'd1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push_cnt;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push_cnt) - 3'(pop);
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/protobuf_wire_parser_unit.sv
// results of an accepted word are written into the registered result queue, which presents them in order
// throughput: one byte per cycle while in_ready is high; the closing byte of a message may add a second result
// in_ready drops while the four-entry result queue holds three or more results
// reset: arst_n clears the parse state to tag expected and empties the result queue
// top level of the protobuf wire parser
`default_nettype none
module protobuf_wire_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  byte_in,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [31:0]      field_number,
	output logic [63:0]      value,
	output logic             final_payload_byte,
	output logic [1:0]       error_code,
	output logic             last_result
);
	import pwp_pkg::*;

	result_t    res0;
	result_t    res1;
	result_t    out_res;
	logic [1:0] push_cnt;
	logic       room;
	logic       in_fire;

	assign in_ready = room;
	assign in_fire  = in_valid && room;

	pwp_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (in_fire),
		.byte_in        (byte_in),
		.end_of_message (end_of_message),
		.res0           (res0),
		.res1           (res1),
		.push_cnt       (push_cnt)
	);

	pwp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (in_fire ? push_cnt : 2'd0),
		.res0      (res0),
		.res1      (res1),
		.out_ready (out_ready),
		.out_res   (out_res),
		.out_valid (out_valid),
		.room      (room)
	);

	assign kind               = out_res.kind;
	assign field_number       = out_res.field_number;
	assign value              = out_res.value;
	assign final_payload_byte = out_res.final_payload_byte;
	assign error_code         = out_res.error_code;
	assign last_result        = out_res.last_result;

endmodule
`default_nettype wire

>>> rtl/core/pwp_checker.sv
// port-level checks for the protobuf wire parser, bound to the top level
`default_nettype none
module pwp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [31:0] field_number,
	input wire logic [63:0] value,
	input wire logic        final_payload_byte,
	input wire logic [1:0]  error_code,
	input wire logic        last_result
);
	import pwp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value)
			&& $stable(last_result))
		else $error("result word changed while stalled");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == K_MSG_OK || kind == K_MSG_ERR)
			|-> last_result && field_number == 32'd0 && value == 64'd0)
		else $error("ok or error result not clean or not last");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == K_MSG_ERR) == (error_code != E_NONE)))
		else $error("error code does not match kind");

	a_final_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_payload_byte |-> kind == K_PAYLOAD && value[63:8] == 56'd0)
		else $error("final payload flag on a non-payload result");

endmodule

bind protobuf_wire_parser_unit pwp_checker u_pwp_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
// testbench for the protobuf wire parser: random and directed messages checked against a decoder
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pwp_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_BYTES = 406;
	// wire types the parser rejects
	localparam logic [2:0] WT_START_GROUP = 3'd3;
	localparam logic [2:0] WT_END_GROUP   = 3'd4;
	localparam logic [2:0] WT_RESERVED6   = 3'd6;
	localparam logic [2:0] WT_RESERVED7   = 3'd7;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_in        = 8'd0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [2:0]  kind;
	logic [31:0] field_number;
	logic [63:0] value;
	logic        final_payload_byte;
	logic [1:0]  error_code;
	logic        last_result;

	// decoder state mirrored from the block
	phase_t      parse_ph   = PH_TAG;
	logic [3:0]  vbytes     = 4'd0;
	logic [63:0] accum      = 64'd0;
	logic [31:0] field_now  = 32'd0;
	logic [63:0] remaining  = 64'd0;

	result_t     pending_results[$];
	result_t     want;
	logic [7:0]  msg[$];
	int          mismatch_count = 0;
	int          bytes_accepted = 0;
	int          idle_pct       = 0;
	int          stall_pct      = 0;
	int          quiet_cycles   = 0;

	protobuf_wire_parser_unit i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.byte_in            (byte_in),
		.end_of_message     (end_of_message),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.field_number       (field_number),
		.value              (value),
		.final_payload_byte (final_payload_byte),
		.error_code         (error_code),
		.last_result        (last_result)
	);

	always #6 clk = ~clk;

	function automatic void push_result(kind_t k, logic [31:0] fnum, logic [63:0] v,
			logic fin, err_t e);
		result_t r;
		r.kind               = k;
		r.field_number       = fnum;
		r.value              = v;
		r.final_payload_byte = fin;
		r.error_code         = e;
		r.last_result        = 1'b0;
		pending_results.push_back(r);
	endfunction

	// expected results of one accepted word
	function automatic void decode_byte(logic [7:0] b, logic eom);
		int          first;
		logic [63:0] v;
		result_t     r;
		first = pending_results.size();
		case (parse_ph)
			PH_TAG, PH_VARINT, PH_LEN: begin
				if (vbytes <= 4'd9)
					accum = accum | ({57'd0, b[6:0]} << (int'(vbytes) * 7));
				vbytes = vbytes + 4'd1;
				if (!b[7]) begin
					v      = accum;
					accum  = 64'd0;
					vbytes = 4'd0;
					if (parse_ph == PH_TAG) begin
						field_now = v[34:3];
						case (v[2:0])
							WT_VINT:    parse_ph = PH_VARINT;
							WT_LEN:     parse_ph = PH_LEN;
							WT_FIXED32: parse_ph = PH_FIX32;
							WT_FIX64:   parse_ph = PH_FIX64;
							default: begin
								push_result(K_MSG_ERR, 32'd0, 64'd0, 1'b0, E_BAD_WIRE);
								parse_ph = PH_DRAIN;
							end
						endcase
					end else if (parse_ph == PH_VARINT) begin
						push_result(K_VARINT, field_now, v, 1'b0, E_NONE);
						parse_ph = PH_TAG;
					end else begin
						push_result(K_LEN_HDR, field_now, v, 1'b0, E_NONE);
						remaining = v;
						parse_ph  = (v == 64'd0) ? PH_TAG : PH_PAYLOAD;
					end
				end else if (int'(vbytes) >= MAX_VARINT_BYTES) begin
					push_result(K_MSG_ERR, 32'd0, 64'd0, 1'b0, E_TOO_LONG);
					parse_ph = PH_DRAIN;
				end
			end
			PH_PAYLOAD: begin
				remaining = remaining - 64'd1;
				push_result(K_PAYLOAD, field_now, {56'd0, b}, remaining == 64'd0, E_NONE);
				if (remaining == 64'd0)
					parse_ph = PH_TAG;
			end
			PH_FIX32: begin
				accum  = accum | ({56'd0, b} << (int'(vbytes[1:0]) * 8));
				vbytes = vbytes + 4'd1;
				if (vbytes >= 4'd4) begin
					push_result(K_FIXED32, field_now, {32'd0, accum[31:0]}, 1'b0, E_NONE);
					accum    = 64'd0;
					vbytes   = 4'd0;
					parse_ph = PH_TAG;
				end
			end
			PH_FIX64: begin
				vbytes = vbytes + 4'd1;
				if (vbytes >= 4'd8) begin
					accum    = 64'd0;
					vbytes   = 4'd0;
					parse_ph = PH_TAG;
				end
			end
			default: ;
		endcase
		if (eom) begin
			if (parse_ph == PH_TAG)
				push_result(K_MSG_OK, 32'd0, 64'd0, 1'b0, E_NONE);
			else if (parse_ph != PH_DRAIN)
				push_result(K_MSG_ERR, 32'd0, 64'd0, 1'b0, E_TRUNCATED);
			parse_ph  = PH_TAG;
			vbytes    = 4'd0;
			accum     = 64'd0;
			field_now = 32'd0;
			remaining = 64'd0;
		end
		if (pending_results.size() > first) begin
			r = pending_results.pop_back();
			r.last_result = 1'b1;
			pending_results.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result expected none got kind %0d", $time, kind);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(kind));
				check_field("field_number", 64'(want.field_number), 64'(field_number));
				check_field("value", want.value, value);
				check_field("final_payload_byte", 64'(want.final_payload_byte),
					64'(final_payload_byte));
				check_field("error_code", 64'(want.error_code), 64'(error_code));
				check_field("last_result", 64'(want.last_result), 64'(last_result));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// valid is left high after acceptance unless a gap or a pause follows
	task automatic send_byte(input logic [7:0] b, input logic eom);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid       <= 1'b1;
		byte_in        <= b;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, eom);
		bytes_accepted++;
	endtask

	task automatic send_msg();
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
		msg.delete();
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// base-128 encoding, optionally padded with redundant groups
	function automatic void add_varint(logic [63:0] v, int pad);
		int         n;
		logic [7:0] bt;
		n = 1;
		while (n < MAX_VARINT_BYTES && (v >> (7 * n)) != 64'd0)
			n++;
		n = (n + pad > MAX_VARINT_BYTES) ? MAX_VARINT_BYTES : n + pad;
		for (int i = 0; i < n; i++) begin
			bt = {1'b0, 7'(v >> (7 * i))};
			// bits above position 63 are dropped by the parser
			if (i == 9)
				bt[6:1] = 6'($urandom);
			if (i < n - 1)
				bt[7] = 1'b1;
			msg.push_back(bt);
		end
	endfunction

	function automatic int rand_pad();
		return ($urandom_range(7) == 0) ? $urandom_range(3) : 0;
	endfunction

	function automatic logic [63:0] rand_wide();
		if ($urandom_range(15) == 0)
			return {64{1'b1}};
		return {$urandom, $urandom} >> $urandom_range(63);
	endfunction

	function automatic void add_tag(logic [31:0] fnum, logic [2:0] wt);
		logic [28:0] hi;
		hi = ($urandom_range(9) == 0) ? 29'($urandom) : 29'd0;
		add_varint({hi, fnum, wt}, rand_pad());
	endfunction

	function automatic logic [31:0] rand_field();
		return $urandom >> $urandom_range(31);
	endfunction

	function automatic void add_rand_bytes(int n);
		repeat (n) msg.push_back(8'($urandom));
	endfunction

	function automatic void add_good_field();
		int len;
		case ($urandom_range(3))
			0: begin
				add_tag(rand_field(), WT_VINT);
				add_varint(rand_wide(), rand_pad());
			end
			1: begin
				add_tag(rand_field(), WT_FIXED32);
				add_rand_bytes(4);
			end
			2: begin
				add_tag(rand_field(), WT_FIX64);
				add_rand_bytes(8);
			end
			default: begin
				len = $urandom_range(6);
				add_tag(rand_field(), WT_LEN);
				add_varint(64'(len), rand_pad());
				add_rand_bytes(len);
			end
		endcase
	endfunction

	task automatic send_random_message();
		int          roll;
		int          cut;
		logic [2:0]  bad_wt[4];
		logic [63:0] big_len;
		bad_wt = '{WT_START_GROUP, WT_END_GROUP, WT_RESERVED6, WT_RESERVED7};
		roll = $urandom_range(99);
		if (roll < 70) begin
			repeat ($urandom_range(1, 4)) add_good_field();
		end else if (roll < 80) begin
			repeat ($urandom_range(1, 3)) add_good_field();
			if ($urandom_range(2) == 0) begin
				// length beyond the data, caught only at the end
				big_len = rand_wide() | 64'd8;
				add_tag(rand_field(), WT_LEN);
				add_varint(big_len, 0);
				add_rand_bytes($urandom_range(3));
			end else begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut)
					void'(msg.pop_back());
			end
		end else if (roll < 87) begin
			repeat ($urandom_range(2)) add_good_field();
			add_tag(rand_field(), bad_wt[$urandom_range(3)]);
			add_rand_bytes($urandom_range(3));
		end else if (roll < 94) begin
			repeat ($urandom_range(2)) add_good_field();
			case ($urandom_range(2))
				0: ;
				1: add_tag(rand_field(), WT_VINT);
				default: add_tag(rand_field(), WT_LEN);
			endcase
			repeat (MAX_VARINT_BYTES) msg.push_back(8'($urandom) | 8'h80);
			add_rand_bytes($urandom_range(3));
		end else begin
			add_rand_bytes($urandom_range(1, 12));
		end
		send_msg();
	endtask

	task automatic test_known_fields();
		add_tag(32'd1, WT_VINT);
		add_varint(64'd150, 0);
		send_msg();
		add_tag(32'd1, WT_FIXED32);
		msg.push_back(8'h78);
		msg.push_back(8'h56);
		msg.push_back(8'h34);
		msg.push_back(8'h12);
		send_msg();
		add_tag(32'd2, WT_LEN);
		add_varint(64'd2, 0);
		msg.push_back(8'hAA);
		msg.push_back(8'h55);
		send_msg();
		// zero length gives just the header
		add_tag(32'd3, WT_LEN);
		add_varint(64'd0, 0);
		send_msg();
		wait_results_drained();
	endtask

	task automatic test_error_cases();
		add_tag(32'd1, WT_START_GROUP);
		msg.push_back(8'hFF);
		send_msg();
		// message ends inside a varint field
		add_tag(32'd1, WT_VINT);
		send_msg();
		// tag made only of continuation bytes, the last of them closing the message
		repeat (MAX_VARINT_BYTES) msg.push_back(8'h80);
		send_msg();
		wait_results_drained();
	endtask

	task automatic test_random_messages(input int idle, input int stall);
		int start;
		idle_pct  = idle;
		stall_pct = stall;
		start     = bytes_accepted;
		while (bytes_accepted - start < RANDOM_BYTES)
			send_random_message();
		// hold the sender until every result is back
		wait_results_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_fields();
		test_error_cases();
		test_random_messages(0, 0);
		test_random_messages(54, 0);
		test_random_messages(0, 54);
		test_random_messages(34, 34);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
